>>> src/shell_string_unescaper_macros.svh
// Assertion macros for the RTL; sse_queue is the file that includes them.
`ifndef SHELL_STRING_UNESCAPER_MACROS_SVH
`define SHELL_STRING_UNESCAPER_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every rising clock edge outside reset.
`define SSE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sse assertion failed");
// Expression must never be true outside reset.
`define SSE_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("sse assertion failed");
`else
`define SSE_ASSERT(lbl, clk, rst_n, prop)
`define SSE_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

>>> src/sse_pkg.sv
package sse_pkg;

    localparam int SSE_QUEUE_DEPTH = 4;

    typedef enum logic [3:0] {
        KIND_LITERAL     = 4'd0,
        KIND_RAW_BYTE    = 4'd1,
        KIND_HOME        = 4'd2,
        KIND_PROCESS     = 4'd3,
        KIND_ANY_STRING  = 4'd4,
        KIND_RECURSIVE   = 4'd5,
        KIND_ANY_CHAR    = 4'd6,
        KIND_VAR         = 4'd7,
        KIND_VAR_SINGLE  = 4'd8,
        KIND_BRACE_OPEN  = 4'd9,
        KIND_BRACE_CLOSE = 4'd10,
        KIND_BRACE_SEP   = 4'd11,
        KIND_SEPARATOR   = 4'd12,
        KIND_END         = 4'd13
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_TRAILING_BS = 2'd1,
        ST_TOO_LARGE   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_SINGLE = 2'd1,
        Q_DOUBLE = 2'd2
    } t_quote;

    typedef enum logic [2:0] {
        FMT_X_LOWER = 3'd0,
        FMT_X_UPPER = 3'd1,
        FMT_U_LOWER = 3'd2,
        FMT_U_UPPER = 3'd3,
        FMT_OCTAL   = 3'd4
    } t_fmt;

    typedef struct packed {
        t_kind         kind;
        logic [30:0]   value;
        logic          replace_previous;
        t_status       status;
        logic          last;
    } t_result;

    // One queue entry: the results caused by one input transaction.
    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_entry;

    localparam logic [20:0] CH_BACKSLASH = 21'h5c;
    localparam logic [20:0] CH_TILDE     = 21'h7e;
    localparam logic [20:0] CH_PERCENT   = 21'h25;
    localparam logic [20:0] CH_STAR      = 21'h2a;
    localparam logic [20:0] CH_QUESTION  = 21'h3f;
    localparam logic [20:0] CH_DOLLAR    = 21'h24;
    localparam logic [20:0] CH_LBRACE    = 21'h7b;
    localparam logic [20:0] CH_RBRACE    = 21'h7d;
    localparam logic [20:0] CH_COMMA     = 21'h2c;
    localparam logic [20:0] CH_SQUOTE    = 21'h27;
    localparam logic [20:0] CH_DQUOTE    = 21'h22;
    localparam logic [20:0] CH_LC_N      = 21'h6e;
    localparam logic [20:0] CH_LC_R      = 21'h72;
    localparam logic [20:0] CH_LC_T      = 21'h74;
    localparam logic [20:0] CH_LC_B      = 21'h62;
    localparam logic [20:0] CH_LC_E      = 21'h65;
    localparam logic [20:0] CH_LC_X      = 21'h78;
    localparam logic [20:0] CH_UC_X      = 21'h58;
    localparam logic [20:0] CH_LC_U      = 21'h75;
    localparam logic [20:0] CH_UC_U      = 21'h55;
    localparam logic [20:0] CH_DIGIT_0   = 21'h30;
    localparam logic [20:0] CH_DIGIT_7   = 21'h37;
    localparam logic [20:0] CH_DIGIT_9   = 21'h39;
    localparam logic [20:0] CH_LC_A      = 21'h61;
    localparam logic [20:0] CH_LC_F      = 21'h66;
    localparam logic [20:0] CH_UC_A      = 21'h41;
    localparam logic [20:0] CH_UC_F      = 21'h46;

    localparam logic [30:0] VAL_LF  = 31'd10;
    localparam logic [30:0] VAL_CR  = 31'd13;
    localparam logic [30:0] VAL_TAB = 31'd9;
    localparam logic [30:0] VAL_BS  = 31'd8;
    localparam logic [30:0] VAL_ESC = 31'd27;

    localparam logic [31:0] LIMIT_ASCII = 32'd127;
    localparam logic [31:0] LIMIT_BYTE  = 32'hff;
    localparam logic [31:0] LIMIT_UCS2  = 32'hffff;
    localparam logic [31:0] LIMIT_WIDE  = 32'h7fffffff;

    localparam logic [3:0] DIGITS_X     = 4'd2;
    localparam logic [3:0] DIGITS_U     = 4'd4;
    localparam logic [3:0] DIGITS_UU    = 4'd8;
    localparam logic [3:0] DIGITS_OCTAL = 4'd2;

    localparam logic [15:0] DEPTH_MAX = 16'hffff;

    function automatic t_result f_res(t_kind kind, logic [30:0] value);
        t_result r;
        r.kind             = kind;
        r.value            = value;
        r.replace_previous = 1'b0;
        r.status           = ST_OK;
        r.last             = 1'b0;
        return r;
    endfunction

    // {valid, digit value}; octal accepts 0..7 only.
    function automatic logic [4:0] f_digit(logic [20:0] c, logic hex);
        logic [4:0] d;
        d = 5'd0;
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_7) begin
            d = {1'b1, c[3:0]};
        end else if (hex && c > CH_DIGIT_7 && c <= CH_DIGIT_9) begin
            d = {1'b1, c[3:0]};
        end else if (hex && ((c >= CH_LC_A && c <= CH_LC_F) ||
                             (c >= CH_UC_A && c <= CH_UC_F))) begin
            d = {1'b1, c[3:0] + 4'd9};
        end
        return d;
    endfunction

    function automatic logic [31:0] f_limit(t_fmt fmt);
        logic [31:0] l;
        unique case (fmt)
            FMT_X_UPPER: l = LIMIT_BYTE;
            FMT_U_LOWER: l = LIMIT_UCS2;
            FMT_U_UPPER: l = LIMIT_WIDE;
            default:     l = LIMIT_ASCII;
        endcase
        return l;
    endfunction

endpackage

>>> src/sse_queue.sv
`include "shell_string_unescaper_macros.svh"

module sse_queue import sse_pkg::*; #(
    parameter int DEPTH = SSE_QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_data,
    input  logic   i_pop,
    output t_entry o_data,
    output logic   o_full,
    output logic   o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `SSE_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full)
    `SSE_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_empty)
    `SSE_ASSERT(a_count_up, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))

endmodule

>>> src/sse_front.sv
module sse_front import sse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_special_mode,
    input  logic        i_valid,
    input  logic [20:0] i_ch,
    input  logic        i_end_of_string,
    input  logic        i_full,
    output logic        o_stall,
    output logic        o_push,
    output t_entry      o_entry
);

    t_quote      r_quote, n_quote, s_quote;
    logic        r_bs, n_bs, s_bs;
    logic        r_num, n_num, s_num;
    t_fmt        r_fmt, n_fmt, s_fmt;
    logic [3:0]  r_dl, n_dl, s_dl;
    logic [31:0] r_acc, n_acc, s_acc;
    logic        r_first, n_first, s_first;
    logic [15:0] r_depth, n_depth, s_depth;
    t_kind       r_last_kind, n_last_kind, s_last_kind;
    t_status     r_err, n_err, s_err;

    logic        accept;
    logic        hex;
    logic [4:0]  dig_raw;
    logic        dig_v;
    logic [3:0]  dig;
    logic        dig_path;
    logic [31:0] acc_shift;
    logic [31:0] acc_fin;
    logic        fin_big;
    t_result     fin_res;
    logic        fin_emit;
    logic        go_char;
    t_kind       lk;
    t_result     c0, c1;
    logic [1:0]  c_cnt;
    logic [1:0]  cnt;
    t_result     slot0, slot1;
    t_result     end_res;
    t_status     st;
    logic [30:0] ch_val;

    assign accept    = i_valid && !i_full;
    assign o_stall   = i_full;
    assign hex       = (r_fmt != FMT_OCTAL);
    assign dig_raw   = f_digit(i_ch, hex);
    assign dig_v     = dig_raw[4];
    assign dig       = dig_raw[3:0];
    assign dig_path  = r_num && dig_v && !i_end_of_string;
    assign acc_shift = hex ? {r_acc[27:0], dig} : {r_acc[28:0], dig[2:0]};
    assign acc_fin   = dig_path ? acc_shift : r_acc;
    assign fin_big   = (acc_fin > f_limit(r_fmt));
    assign fin_res   = f_res((r_fmt == FMT_X_UPPER) ? KIND_RAW_BYTE : KIND_LITERAL,
                             acc_fin[30:0]);
    assign ch_val    = {10'd0, i_ch};

    always_comb begin
        s_quote     = r_quote;
        s_bs        = r_bs;
        s_num       = r_num;
        s_fmt       = r_fmt;
        s_dl        = r_dl;
        s_acc       = r_acc;
        s_first     = 1'b0;
        s_depth     = r_depth;
        s_err       = r_err;
        fin_emit    = 1'b0;
        go_char     = 1'b0;
        c0          = f_res(KIND_LITERAL, '0);
        c1          = f_res(KIND_LITERAL, '0);
        c_cnt       = 2'd0;
        st          = r_err;
        end_res     = f_res(KIND_END, '0);
        lk          = r_last_kind;

        if (i_end_of_string) begin
            if (r_err == ST_OK) begin
                if (r_num && fin_big) begin
                    st = ST_TOO_LARGE;
                end else if (r_bs) begin
                    st = ST_TRAILING_BS;
                end
                fin_emit = r_num && !fin_big;
            end
            end_res.status = st;
            end_res.last   = 1'b1;
            c0             = end_res;
            c_cnt          = 2'd1;
            // close the string: back to reset values
            s_quote = Q_NONE;
            s_bs    = 1'b0;
            s_num   = 1'b0;
            s_fmt   = FMT_X_LOWER;
            s_dl    = '0;
            s_acc   = '0;
            s_first = 1'b1;
            s_depth = '0;
            s_err   = ST_OK;
        end else if (r_err == ST_OK) begin
            go_char = 1'b1;
            if (r_num) begin
                if (dig_v) begin
                    s_acc   = acc_shift;
                    s_dl    = (r_dl == '0) ? '0 : r_dl - 4'd1;
                    go_char = 1'b0;
                    if (s_dl == '0) begin
                        s_num = 1'b0;
                        if (fin_big) s_err = ST_TOO_LARGE;
                        else         fin_emit = 1'b1;
                    end
                end else begin
                    s_num = 1'b0;
                    s_dl  = '0;
                    if (fin_big) begin
                        s_err   = ST_TOO_LARGE;
                        go_char = 1'b0;
                    end else begin
                        fin_emit = 1'b1;
                    end
                end
            end
            if (fin_emit) lk = fin_res.kind;

            if (go_char) begin
                unique case (r_quote)
                    Q_SINGLE: begin
                        c_cnt = 2'd1;
                        c0    = f_res(KIND_LITERAL, ch_val);
                        if (r_bs) begin
                            s_bs = 1'b0;
                            if (i_ch != CH_BACKSLASH && i_ch != CH_SQUOTE) begin
                                c0    = f_res(KIND_LITERAL, {10'd0, CH_BACKSLASH});
                                c1    = f_res(KIND_LITERAL, ch_val);
                                c_cnt = 2'd2;
                            end
                        end else if (i_ch == CH_BACKSLASH) begin
                            s_bs  = 1'b1;
                            c_cnt = 2'd0;
                        end else if (i_ch == CH_SQUOTE) begin
                            s_quote = Q_NONE;
                            c0      = f_res(KIND_SEPARATOR, '0);
                        end
                    end
                    Q_DOUBLE: begin
                        c_cnt = 2'd1;
                        c0    = f_res(KIND_LITERAL, ch_val);
                        if (r_bs) begin
                            s_bs = 1'b0;
                            if (i_ch != CH_BACKSLASH && i_ch != CH_DOLLAR &&
                                i_ch != CH_DQUOTE) begin
                                c0    = f_res(KIND_LITERAL, {10'd0, CH_BACKSLASH});
                                c1    = f_res(KIND_LITERAL, ch_val);
                                c_cnt = 2'd2;
                            end
                        end else if (i_ch == CH_BACKSLASH) begin
                            s_bs  = 1'b1;
                            c_cnt = 2'd0;
                        end else if (i_ch == CH_DQUOTE) begin
                            s_quote = Q_NONE;
                            c0      = f_res(KIND_SEPARATOR, '0);
                        end else if (i_ch == CH_DOLLAR && i_special_mode) begin
                            c0 = f_res(KIND_VAR_SINGLE, '0);
                        end
                    end
                    default: begin
                        c_cnt = 2'd1;
                        c0    = f_res(KIND_LITERAL, ch_val);
                        if (r_bs) begin
                            s_bs = 1'b0;
                            unique case (i_ch)
                                CH_LC_N: c0 = f_res(KIND_LITERAL, VAL_LF);
                                CH_LC_R: c0 = f_res(KIND_LITERAL, VAL_CR);
                                CH_LC_T: c0 = f_res(KIND_LITERAL, VAL_TAB);
                                CH_LC_B: c0 = f_res(KIND_LITERAL, VAL_BS);
                                CH_LC_E: c0 = f_res(KIND_LITERAL, VAL_ESC);
                                CH_LC_X: begin
                                    c_cnt = 2'd0; s_num = 1'b1; s_fmt = FMT_X_LOWER;
                                    s_dl = DIGITS_X; s_acc = '0;
                                end
                                CH_UC_X: begin
                                    c_cnt = 2'd0; s_num = 1'b1; s_fmt = FMT_X_UPPER;
                                    s_dl = DIGITS_X; s_acc = '0;
                                end
                                CH_LC_U: begin
                                    c_cnt = 2'd0; s_num = 1'b1; s_fmt = FMT_U_LOWER;
                                    s_dl = DIGITS_U; s_acc = '0;
                                end
                                CH_UC_U: begin
                                    c_cnt = 2'd0; s_num = 1'b1; s_fmt = FMT_U_UPPER;
                                    s_dl = DIGITS_UU; s_acc = '0;
                                end
                                default: begin
                                    if (i_ch >= CH_DIGIT_0 && i_ch <= CH_DIGIT_7) begin
                                        c_cnt = 2'd0; s_num = 1'b1; s_fmt = FMT_OCTAL;
                                        s_dl  = DIGITS_OCTAL;
                                        s_acc = {29'd0, i_ch[2:0]};
                                    end
                                end
                            endcase
                        end else begin
                            unique case (i_ch)
                                CH_BACKSLASH: begin
                                    s_bs  = 1'b1;
                                    c_cnt = 2'd0;
                                end
                                CH_TILDE: begin
                                    if (i_special_mode && r_first) c0 = f_res(KIND_HOME, '0);
                                end
                                CH_PERCENT: begin
                                    if (i_special_mode && r_first) c0 = f_res(KIND_PROCESS, '0);
                                end
                                CH_STAR: begin
                                    if (i_special_mode) begin
                                        if (lk == KIND_ANY_STRING) begin
                                            c0 = f_res(KIND_RECURSIVE, '0);
                                            c0.replace_previous = 1'b1;
                                        end else begin
                                            c0 = f_res(KIND_ANY_STRING, '0);
                                        end
                                    end
                                end
                                CH_QUESTION: begin
                                    if (i_special_mode) c0 = f_res(KIND_ANY_CHAR, '0);
                                end
                                CH_DOLLAR: begin
                                    if (i_special_mode) c0 = f_res(KIND_VAR, '0);
                                end
                                CH_LBRACE: begin
                                    if (i_special_mode) begin
                                        if (r_depth != DEPTH_MAX) s_depth = r_depth + 16'd1;
                                        c0 = f_res(KIND_BRACE_OPEN, '0);
                                    end
                                end
                                CH_RBRACE: begin
                                    if (i_special_mode) begin
                                        if (r_depth != '0) s_depth = r_depth - 16'd1;
                                        c0 = f_res(KIND_BRACE_CLOSE, '0);
                                    end
                                end
                                CH_COMMA: begin
                                    if (i_special_mode && r_depth != '0 &&
                                        lk != KIND_BRACE_SEP) begin
                                        c0 = f_res(KIND_BRACE_SEP, '0);
                                    end
                                end
                                CH_SQUOTE: begin
                                    s_quote = Q_SINGLE;
                                    c0      = f_res(KIND_SEPARATOR, '0);
                                end
                                CH_DQUOTE: begin
                                    s_quote = Q_DOUBLE;
                                    c0      = f_res(KIND_SEPARATOR, '0);
                                end
                                default: ;
                            endcase
                        end
                    end
                endcase
            end
        end

        // a finished numeric escape always goes first
        slot0 = fin_emit ? fin_res : c0;
        slot1 = fin_emit ? c0 : c1;
        cnt   = {1'b0, fin_emit} + c_cnt;

        if (i_end_of_string) begin
            s_last_kind = KIND_LITERAL;
        end else if (cnt == 2'd2) begin
            s_last_kind = slot1.kind;
        end else if (cnt == 2'd1) begin
            s_last_kind = slot0.kind;
        end else begin
            s_last_kind = r_last_kind;
        end
    end

    assign o_push        = accept && (cnt != 2'd0);
    assign o_entry.two   = (cnt == 2'd2);
    assign o_entry.r0    = slot0;
    assign o_entry.r1    = slot1;

    always_comb begin
        n_quote     = accept ? s_quote     : r_quote;
        n_bs        = accept ? s_bs        : r_bs;
        n_num       = accept ? s_num       : r_num;
        n_fmt       = accept ? s_fmt       : r_fmt;
        n_dl        = accept ? s_dl        : r_dl;
        n_acc       = accept ? s_acc       : r_acc;
        n_first     = accept ? s_first     : r_first;
        n_depth     = accept ? s_depth     : r_depth;
        n_last_kind = accept ? s_last_kind : r_last_kind;
        n_err       = accept ? s_err       : r_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote     <= Q_NONE;
            r_bs        <= 1'b0;
            r_num       <= 1'b0;
            r_fmt       <= FMT_X_LOWER;
            r_dl        <= '0;
            r_acc       <= '0;
            r_first     <= 1'b1;
            r_depth     <= '0;
            r_last_kind <= KIND_LITERAL;
            r_err       <= ST_OK;
        end else begin
            r_quote     <= n_quote;
            r_bs        <= n_bs;
            r_num       <= n_num;
            r_fmt       <= n_fmt;
            r_dl        <= n_dl;
            r_acc       <= n_acc;
            r_first     <= n_first;
            r_depth     <= n_depth;
            r_last_kind <= n_last_kind;
            r_err       <= n_err;
        end
    end

endmodule

>>> src/sse_back.sv
module sse_back import sse_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_entry  i_data,
    input  logic    i_empty,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic   r_busy, n_busy;
    logic   r_sel, n_sel;
    t_entry r_entry, n_entry;
    logic   fire;
    logic   need_load;

    assign fire      = r_busy && !i_stall;
    assign need_load = !r_busy || (fire && (r_sel || !r_entry.two));
    assign o_pop     = need_load && !i_empty;
    assign o_valid   = r_busy;
    assign o_result  = r_sel ? r_entry.r1 : r_entry.r0;

    always_comb begin
        n_busy  = r_busy;
        n_sel   = r_sel;
        n_entry = r_entry;
        if (o_pop) begin
            n_entry = i_data;
            n_sel   = 1'b0;
            n_busy  = 1'b1;
        end else if (need_load) begin
            n_busy = 1'b0;
        end else if (fire) begin
            n_sel = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sel  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_sel  <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

>>> src/shell_string_unescaper.sv
// Path: an accepted transaction is written into the entry queue and then registered in
//   the output stage, where its first result becomes valid.
// Throughput: one input transaction per cycle while the entry queue has room; one result
//   per cycle while the output is not stalled, so two-result inputs (escape close plus
//   character, end with a flushed escape) drain at half rate; a full queue stalls the input.
// Reset: synchronous, active low; clears string state, queue, output stage and special mode.
module shell_string_unescaper import sse_pkg::*; #(
    parameter int QUEUE_DEPTH = SSE_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [20:0] i_ch,
    input  logic        i_end_of_string,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_kind,
    output logic [30:0] o_value,
    output logic        o_replace_previous,
    output logic [1:0]  o_status,
    output logic        o_last
);

    logic    r_special_mode;
    logic    push, pop, full, empty;
    t_entry  push_entry, head_entry;
    t_result cur;

    // Hold the special-mode bit; the user must write it only while idle, the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_special_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_special_mode <= i_cfg_wr_data;
        end
    end

    // Front: classify each character, track quote and escape state,
    // and push the one or two results of the transaction as one entry.
    sse_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_special_mode  (r_special_mode),
        .i_valid         (i_in_valid),
        .i_ch            (i_ch),
        .i_end_of_string (i_end_of_string),
        .i_full          (full),
        .o_stall         (o_in_stall),
        .o_push          (push),
        .o_entry         (push_entry)
    );

    // Short queue decouples front stalls from back stalls.
    sse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_data  (head_entry),
        .o_full  (full),
        .o_empty (empty)
    );

    // Back: register an entry and hand out its results one per transaction.
    sse_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (head_entry),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (cur)
    );

    assign o_kind             = cur.kind;
    assign o_value            = cur.value;
    assign o_replace_previous = cur.replace_previous;
    assign o_status           = cur.status;
    assign o_last             = cur.last;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import sse_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 8;       // quiet time before a mode write
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int TAIL_CYCLES   = 20;
    localparam int CYCLE_LIMIT   = 900000;
    localparam int MAX_REPORTS   = 100;
    localparam int PHASE_ITEMS   = 68;

    // Commands that the stimulus builder queues for the driver.
    typedef enum {CMD_CHAR, CMD_CONFIG, CMD_DRAIN, CMD_IDLE, CMD_HOLD} t_cmd_op;

    typedef struct {
        t_cmd_op     op;
        logic [20:0] ch;
        logic        eos;
        int          arg0;
        int          arg1;
    } t_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [20:0] i_ch = '0;
    logic        i_end_of_string = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [3:0]  o_kind;
    logic [30:0] o_value;
    logic        o_replace_previous;
    logic [1:0]  o_status;
    logic        o_last;

    shell_string_unescaper u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_ch               (i_ch),
        .i_end_of_string    (i_end_of_string),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_kind             (o_kind),
        .o_value            (o_value),
        .o_replace_previous (o_replace_previous),
        .o_status           (o_status),
        .o_last             (o_last)
    );

    // Stimulus and bookkeeping.
    t_cmd    stim_q[$];
    t_result tokens_due[$];     // decoded tokens still owed by the block
    int      items_queued   = 0;
    int      items_sent     = 0;
    int      strings_sent   = 0;
    int      tokens_checked = 0;
    int      cfg_writes     = 0;
    int      fault_count    = 0;
    int      cycle_count    = 0;
    logic    stim_done      = 1'b0;

    // Idle knobs and the hold-off request, owned by the driver.
    int      send_gap_pct   = 0;
    int      stall_pct      = 0;
    logic    hold_req       = 1'b0;
    logic    draining       = 1'b0;
    int      settle_left    = 0;
    int      hold_left      = 0;

    // Decoder state mirrored by the predictor.
    logic        pr_special;
    t_quote      pr_quote;
    logic        pr_bs;
    logic        pr_num_active;
    t_fmt        pr_fmt;
    logic [3:0]  pr_digits_left;
    logic [31:0] pr_acc;
    logic        pr_first;
    logic [15:0] pr_depth;
    t_kind       pr_last_kind;
    t_status     pr_err;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    function automatic void clear_string();
        pr_quote       = Q_NONE;
        pr_bs          = 1'b0;
        pr_num_active  = 1'b0;
        pr_fmt         = FMT_X_LOWER;
        pr_digits_left = '0;
        pr_acc         = '0;
        pr_first       = 1'b1;
        pr_depth       = '0;
        pr_last_kind   = KIND_LITERAL;
        pr_err         = ST_OK;
    endfunction

    function automatic void push_result(t_kind k, logic [30:0] v, logic repl,
                                        t_status st, logic lst);
        t_result r;
        r.kind             = k;
        r.value            = v;
        r.replace_previous = repl;
        r.status           = st;
        r.last             = lst;
        tokens_due.push_back(r);
        pr_last_kind = k;
    endfunction

    function automatic void push_token(t_kind k, logic [30:0] v);
        push_result(k, v, 1'b0, ST_OK, 1'b0);
    endfunction

    // Emit the token kind when the character acts as a token, else the literal.
    function automatic void token_or_literal(logic is_token, t_kind k, logic [20:0] c);
        if (is_token) begin
            push_token(k, '0);
        end else begin
            push_token(KIND_LITERAL, 31'(c));
        end
    endfunction

    function automatic int digit_value(logic [20:0] c, logic hex_ok);
        int d;
        d = -1;
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_7) begin
            d = int'(c - CH_DIGIT_0);
        end else if (hex_ok && c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            d = int'(c - CH_DIGIT_0);
        end else if (hex_ok && c >= CH_LC_A && c <= CH_LC_F) begin
            d = int'(c - CH_LC_A) + 10;
        end else if (hex_ok && c >= CH_UC_A && c <= CH_UC_F) begin
            d = int'(c - CH_UC_A) + 10;
        end
        return d;
    endfunction

    function automatic void open_number(t_fmt f, logic [3:0] digits, logic [31:0] acc);
        pr_num_active  = 1'b1;
        pr_fmt         = f;
        pr_digits_left = digits;
        pr_acc         = acc;
    endfunction

    // Close a numeric escape: emit its value or flag it as too large.
    function automatic void close_number();
        logic [31:0] cap;
        case (pr_fmt)
            FMT_X_UPPER: cap = LIMIT_BYTE;
            FMT_U_LOWER: cap = LIMIT_UCS2;
            FMT_U_UPPER: cap = LIMIT_WIDE;
            default:     cap = LIMIT_ASCII;
        endcase
        pr_num_active  = 1'b0;
        pr_digits_left = '0;
        if (pr_acc > cap) begin
            pr_err = ST_TOO_LARGE;
        end else if (pr_fmt == FMT_X_UPPER) begin
            push_token(KIND_RAW_BYTE, pr_acc[30:0]);
        end else begin
            push_token(KIND_LITERAL, pr_acc[30:0]);
        end
    endfunction

    function automatic void take_unquoted(logic [20:0] c);
        if (pr_bs) begin
            pr_bs = 1'b0;
            case (c)
                CH_LC_N: push_token(KIND_LITERAL, VAL_LF);
                CH_LC_R: push_token(KIND_LITERAL, VAL_CR);
                CH_LC_T: push_token(KIND_LITERAL, VAL_TAB);
                CH_LC_B: push_token(KIND_LITERAL, VAL_BS);
                CH_LC_E: push_token(KIND_LITERAL, VAL_ESC);
                CH_LC_X: open_number(FMT_X_LOWER, DIGITS_X, '0);
                CH_UC_X: open_number(FMT_X_UPPER, DIGITS_X, '0);
                CH_LC_U: open_number(FMT_U_LOWER, DIGITS_U, '0);
                CH_UC_U: open_number(FMT_U_UPPER, DIGITS_UU, '0);
                default: begin
                    if (c >= CH_DIGIT_0 && c <= CH_DIGIT_7) begin
                        open_number(FMT_OCTAL, DIGITS_OCTAL, 32'(c - CH_DIGIT_0));
                    end else begin
                        push_token(KIND_LITERAL, 31'(c));
                    end
                end
            endcase
        end else begin
            case (c)
                CH_BACKSLASH: pr_bs = 1'b1;
                CH_TILDE:     token_or_literal(pr_special && pr_first, KIND_HOME, c);
                CH_PERCENT:   token_or_literal(pr_special && pr_first, KIND_PROCESS, c);
                CH_QUESTION:  token_or_literal(pr_special, KIND_ANY_CHAR, c);
                CH_DOLLAR:    token_or_literal(pr_special, KIND_VAR, c);
                CH_STAR: begin
                    // A second star folds the previous any-string into a recursive one.
                    if (!pr_special) begin
                        push_token(KIND_LITERAL, 31'(c));
                    end else if (pr_last_kind == KIND_ANY_STRING) begin
                        push_result(KIND_RECURSIVE, '0, 1'b1, ST_OK, 1'b0);
                    end else begin
                        push_token(KIND_ANY_STRING, '0);
                    end
                end
                CH_LBRACE: begin
                    if (pr_special && pr_depth != DEPTH_MAX) pr_depth++;
                    token_or_literal(pr_special, KIND_BRACE_OPEN, c);
                end
                CH_RBRACE: begin
                    if (pr_special && pr_depth != 0) pr_depth--;
                    token_or_literal(pr_special, KIND_BRACE_CLOSE, c);
                end
                CH_COMMA: token_or_literal(pr_special && pr_depth != 0 &&
                                           pr_last_kind != KIND_BRACE_SEP, KIND_BRACE_SEP, c);
                CH_SQUOTE: begin
                    pr_quote = Q_SINGLE;
                    push_token(KIND_SEPARATOR, '0);
                end
                CH_DQUOTE: begin
                    pr_quote = Q_DOUBLE;
                    push_token(KIND_SEPARATOR, '0);
                end
                default: push_token(KIND_LITERAL, 31'(c));
            endcase
        end
    endfunction

    function automatic void take_single(logic [20:0] c);
        if (pr_bs) begin
            pr_bs = 1'b0;
            if (c != CH_BACKSLASH && c != CH_SQUOTE) push_token(KIND_LITERAL, 31'(CH_BACKSLASH));
            push_token(KIND_LITERAL, 31'(c));
        end else if (c == CH_BACKSLASH) begin
            pr_bs = 1'b1;
        end else if (c == CH_SQUOTE) begin
            pr_quote = Q_NONE;
            push_token(KIND_SEPARATOR, '0);
        end else begin
            push_token(KIND_LITERAL, 31'(c));
        end
    endfunction

    function automatic void take_double(logic [20:0] c);
        if (pr_bs) begin
            pr_bs = 1'b0;
            if (c != CH_BACKSLASH && c != CH_DOLLAR && c != CH_DQUOTE) begin
                push_token(KIND_LITERAL, 31'(CH_BACKSLASH));
            end
            push_token(KIND_LITERAL, 31'(c));
        end else if (c == CH_BACKSLASH) begin
            pr_bs = 1'b1;
        end else if (c == CH_DQUOTE) begin
            pr_quote = Q_NONE;
            push_token(KIND_SEPARATOR, '0);
        end else begin
            token_or_literal(pr_special && c == CH_DOLLAR, KIND_VAR_SINGLE, c);
        end
    endfunction

    // Work out the tokens owed for one accepted input transaction.
    function automatic void unescape_step(logic [20:0] c, logic eos);
        int   d;
        logic done;
        done = 1'b0;
        if (eos) begin
            if (pr_err == ST_OK) begin
                if (pr_num_active) close_number();
                if (pr_err == ST_OK && pr_bs) pr_err = ST_TRAILING_BS;
            end
            push_result(KIND_END, '0, 1'b0, pr_err, 1'b1);
            clear_string();
        end else if (pr_err != ST_OK) begin
            pr_first = 1'b0;      // swallow everything after an error
        end else begin
            if (pr_num_active) begin
                d = digit_value(c, pr_fmt != FMT_OCTAL);
                if (d >= 0) begin
                    pr_acc = pr_acc * ((pr_fmt != FMT_OCTAL) ? 32'd16 : 32'd8) + 32'(d);
                    if (pr_digits_left != 0) pr_digits_left--;
                    if (pr_digits_left == 0) close_number();
                    done = 1'b1;
                end else begin
                    // A non-digit closes the escape and, unless the value is too large, is then decoded as usual.
                    close_number();
                    done = (pr_err != ST_OK);
                end
            end
            if (!done) begin
                case (pr_quote)
                    Q_SINGLE: take_single(c);
                    Q_DOUBLE: take_double(c);
                    default:  take_unquoted(c);
                endcase
            end
            pr_first = 1'b0;
        end
    endfunction

    //------------------------------------------------------------------
    // Stimulus builder
    //------------------------------------------------------------------

    task automatic push_cmd(t_cmd_op op, logic [20:0] c, logic eos, int a0, int a1);
        t_cmd cmd;
        cmd.op   = op;
        cmd.ch   = c;
        cmd.eos  = eos;
        cmd.arg0 = a0;
        cmd.arg1 = a1;
        stim_q.push_back(cmd);
        if (op == CMD_CHAR) items_queued++;
    endtask

    task automatic queue_char(logic [20:0] c);
        push_cmd(CMD_CHAR, c, 1'b0, 0, 0);
    endtask

    // The character lane is don't-care on the end transaction; randomize it.
    task automatic queue_end();
        push_cmd(CMD_CHAR, 21'($urandom_range(32'h10ffff)), 1'b1, 0, 0);
    endtask

    task automatic queue_text(string s);
        for (int k = 0; k < s.len(); k++) queue_char(21'(s[k]));
        queue_end();
    endtask

    // Drain the block, wait for it to settle, then write the mode register.
    task automatic queue_mode(logic special);
        push_cmd(CMD_DRAIN, '0, 1'b0, 0, 0);
        push_cmd(CMD_CONFIG, '0, 1'b0, int'(special), 0);
    endtask

    task automatic queue_idle(int send_pct, int recv_pct);
        push_cmd(CMD_IDLE, '0, 1'b0, send_pct, recv_pct);
    endtask

    function automatic logic [20:0] pick_punct();
        logic [20:0] c;
        case ($urandom_range(11))
            0:       c = CH_TILDE;
            1:       c = CH_PERCENT;
            2:       c = CH_STAR;
            3:       c = CH_QUESTION;
            4:       c = CH_DOLLAR;
            5:       c = CH_LBRACE;
            6:       c = CH_RBRACE;
            7:       c = CH_COMMA;
            8:       c = CH_SQUOTE;
            9:       c = CH_DQUOTE;
            10:      c = CH_BACKSLASH;
            default: c = CH_STAR;
        endcase
        return c;
    endfunction

    function automatic logic [20:0] pick_hex();
        logic [20:0] c;
        case ($urandom_range(2))
            0:       c = CH_DIGIT_0 + 21'($urandom_range(9));
            1:       c = CH_LC_A + 21'($urandom_range(5));
            default: c = CH_UC_A + 21'($urandom_range(5));
        endcase
        return c;
    endfunction

    function automatic logic [20:0] pick_escape_letter();
        logic [20:0] c;
        case ($urandom_range(14))
            0:       c = CH_LC_N;
            1:       c = CH_LC_R;
            2:       c = CH_LC_T;
            3:       c = CH_LC_B;
            4:       c = CH_LC_E;
            5:       c = CH_LC_X;
            6:       c = CH_UC_X;
            7:       c = CH_LC_U;
            8:       c = CH_UC_U;
            9:       c = CH_DIGIT_0 + 21'($urandom_range(7));
            10:      c = CH_BACKSLASH;
            11:      c = CH_SQUOTE;
            12:      c = CH_DQUOTE;
            13:      c = CH_DOLLAR;
            default: c = 21'($urandom_range(32, 126));
        endcase
        return c;
    endfunction

    // Leading digit mostly low so that many escapes stay within their limit.
    task automatic queue_hex_run(int n);
        for (int k = 0; k < n; k++) begin
            if (k == 0 && $urandom_range(9) < 7) begin
                queue_char(CH_DIGIT_0 + 21'($urandom_range(7)));
            end else begin
                queue_char(pick_hex());
            end
        end
    endtask

    task automatic queue_escape();
        logic [20:0] c;
        int          n;
        c = pick_escape_letter();
        queue_char(CH_BACKSLASH);
        queue_char(c);
        if (c == CH_LC_X || c == CH_UC_X) begin
            n = $urandom_range(3);
        end else if (c == CH_LC_U) begin
            n = $urandom_range(5);
        end else if (c == CH_UC_U) begin
            n = $urandom_range(9);
        end else begin
            n = 0;
        end
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_7) begin
            // Octal digits, now and then an 8 or 9 that closes the escape early.
            n = $urandom_range(3);
            for (int k = 0; k < n; k++) begin
                queue_char(CH_DIGIT_0 + 21'($urandom_range($urandom_range(3) == 0 ? 9 : 7)));
            end
        end else begin
            queue_hex_run(n);
        end
    endtask

    task automatic queue_random_string();
        int parts;
        int pick;
        parts = $urandom_range(1, 8);
        for (int p = 0; p < parts; p++) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                queue_escape();
            end else if (pick < 60) begin
                queue_char(pick_punct());
            end else if (pick < 80) begin
                queue_char(21'($urandom_range(32, 126)));
            end else if (pick < 90) begin
                queue_char(pick_hex());
            end else if (pick < 95) begin
                queue_char(21'($urandom_range(31)));
            end else begin
                queue_char(21'($urandom_range(32'h10ffff)));
            end
        end
        // Now and then leave a backslash dangling before the end.
        if ($urandom_range(9) == 0) queue_char(CH_BACKSLASH);
        queue_end();
    endtask

    //------------------------------------------------------------------
    // Driver: offer queued characters, hold a stalled transaction,
    // and run mode writes, drains and idle changes in between.
    //------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_cmd        cmd;
        logic        next_valid;
        logic [20:0] next_ch;
        logic        next_eos;
        logic        next_wr;
        logic        next_wd;
        logic        next_hold;
        next_valid = 1'b0;
        next_ch    = i_ch;
        next_eos   = i_end_of_string;
        next_wr    = 1'b0;
        next_wd    = i_cfg_wr_data;
        next_hold  = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && o_in_stall) begin
                next_valid = 1'b1;                  // hold the stalled transaction
            end else begin
                if (i_in_valid) begin
                    unescape_step(i_ch, i_end_of_string);
                    items_sent++;
                    if (i_end_of_string) strings_sent++;
                end
                if (settle_left != 0) begin
                    settle_left--;
                end else if (draining) begin
                    // Sender pauses until every owed token has come back.
                    if (tokens_due.size() == 0) begin
                        draining    = 1'b0;
                        settle_left = SETTLE_CYCLES;
                    end
                end else if (stim_q.size() != 0) begin
                    cmd = stim_q[0];
                    case (cmd.op)
                        CMD_CHAR: begin
                            if ($urandom_range(99) >= send_gap_pct) begin
                                void'(stim_q.pop_front());
                                next_valid = 1'b1;
                                next_ch    = cmd.ch;
                                next_eos   = cmd.eos;
                            end
                        end
                        CMD_CONFIG: begin
                            void'(stim_q.pop_front());
                            next_wr    = 1'b1;
                            next_wd    = cmd.arg0[0];
                            pr_special = cmd.arg0[0];
                            cfg_writes++;
                        end
                        CMD_DRAIN: begin
                            void'(stim_q.pop_front());
                            draining = 1'b1;
                        end
                        CMD_IDLE: begin
                            void'(stim_q.pop_front());
                            send_gap_pct = cmd.arg0;
                            stall_pct   <= cmd.arg1;
                        end
                        default: begin
                            void'(stim_q.pop_front());
                            next_hold = 1'b1;
                        end
                    endcase
                end else begin
                    stim_done <= 1'b1;
                end
            end
        end
        i_in_valid      <= next_valid;
        i_ch            <= next_ch;
        i_end_of_string <= next_eos;
        i_cfg_wr_en     <= next_wr;
        i_cfg_wr_data   <= next_wd;
        hold_req        <= next_hold;
    end

    //------------------------------------------------------------------
    // Monitor: check each accepted token against the oldest one owed,
    // and drive the output stall (random, or a long hold-off on request).
    //------------------------------------------------------------------

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        if (fault_count < MAX_REPORTS) begin
            $display("tb mismatch at cycle %0d, token %0d: %s got 0x%0h want 0x%0h",
                     cycle_count, tokens_checked, field, got, want);
        end
        fault_count++;
    endtask

    task automatic check_token();
        t_result want;
        if (tokens_due.size() == 0) begin
            report_mismatch("unexpected token kind", 32'(o_kind), 32'd0);
        end else begin
            want = tokens_due.pop_front();
            if (o_kind !== want.kind) report_mismatch("kind", 32'(o_kind), 32'(want.kind));
            if (o_value !== want.value) report_mismatch("value", 32'(o_value), 32'(want.value));
            if (o_replace_previous !== want.replace_previous) begin
                report_mismatch("replace_previous", 32'(o_replace_previous),
                                32'(want.replace_previous));
            end
            if (o_status !== want.status) begin
                report_mismatch("status", 32'(o_status), 32'(want.status));
            end
            if (o_last !== want.last) report_mismatch("last", 32'(o_last), 32'(want.last));
        end
        tokens_checked++;
    endtask

    always @(posedge i_clk) begin
        logic next_stall;
        next_stall = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) check_token();
            if (hold_req) hold_left = HOLD_CYCLES;
            if (hold_left != 0) begin
                hold_left--;
                next_stall = 1'b1;
            end else begin
                next_stall = ($urandom_range(99) < stall_pct);
            end
        end
        i_out_stall <= next_stall;
    end

    // Watchdog: abort a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Stimulus plan and end of run
    //------------------------------------------------------------------

    initial begin
        int target;
        pr_special = 1'b0;
        clear_string();

        queue_idle(7, 60);
        queue_mode(1'b0);
        // Plain mode: top and bottom of the character range.
        queue_char(21'h10ffff);
        queue_char(21'h0);
        queue_end();

        queue_mode(1'b1);
        // Home, any-string folded to recursive, braces, a doubled comma, and a
        // trailing backslash at the end.
        queue_text("~**{,,}\\");
        // Process token, raw byte at its limit, hex escape flushed by the end.
        queue_text("%\\Xff\\x8");
        // Hex escape over its limit.
        queue_text("\\x80");

        // Random strings in six phases: alternate the mode, rotate the idling.
        for (int ph = 0; ph < 6; ph++) begin
            queue_mode(ph % 2 == 0);
            if (ph == 0) queue_idle(7, 60);
            else if (ph == 2) queue_idle(60, 7);
            else if (ph == 4) queue_idle(0, 0);
            // Hold the receiver off while characters keep coming.
            if (ph == 1 || ph == 4) push_cmd(CMD_HOLD, '0, 1'b0, 0, 0);
            target = items_queued + PHASE_ITEMS;
            while (items_queued < target) begin
                queue_random_string();
                if (ph == 3 && items_queued > target - PHASE_ITEMS / 2 &&
                    items_queued < target - PHASE_ITEMS / 2 + 8) begin
                    push_cmd(CMD_DRAIN, '0, 1'b0, 0, 0);
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(stim_done && tokens_due.size() == 0)) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tokens_due.size() != 0) begin
            report_mismatch("tokens never delivered", 32'(tokens_due.size()), 32'd0);
        end

        $display("tb summary: %0d strings, %0d characters in, %0d tokens checked",
                 strings_sent, items_sent, tokens_checked);
        $display("tb summary: %0d mode writes, %0d mismatches, %0d cycles",
                 cfg_writes, fault_count, cycle_count);
        if (fault_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

>>> shell_string_unescaper.f
+incdir+src
src/sse_pkg.sv
src/sse_queue.sv
src/sse_front.sv
src/sse_back.sv
src/shell_string_unescaper.sv
tb/tb.sv
